### design/bresenham_line_raster_macros.svh
`ifndef BRESENHAM_LINE_RASTER_MACROS_SVH
`define BRESENHAM_LINE_RASTER_MACROS_SVH

// Checks that a condition in one cycle brings a consequence in the same cycle.
`define BLR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition in one cycle brings a consequence from the next cycle on.
`define BLR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/blr_pkg.sv
`default_nettype none

package blr_pkg;

    localparam int X_W       = 7;
    localparam int Y_W       = 5;
    localparam int IDX_W     = 9;
    localparam int DATA_W    = 8;
    localparam int PAGE_ROWS = 8;
    localparam int BIT_W     = 3;
    localparam int ERR_W     = 10;

    localparam int DEF_SCREEN_WIDTH  = 128;
    localparam int DEF_SCREEN_HEIGHT = 32;
    localparam int DEF_STORE_BYTES   =
        ((DEF_SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS) * DEF_SCREEN_WIDTH;
    localparam int DEF_ADDR_W        = $clog2(DEF_STORE_BYTES);

    localparam logic KIND_DRAW = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic           valid;
        logic           last;
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
    } pixel_t;

endpackage

`default_nettype wire

### design/bresenham_line_raster.sv
`default_nettype none

// Line rasterizer over a page-major monochrome frame store, where pixel (x, y) is bit
// y mod 8 of byte (y/8)*SCREEN_WIDTH + x. A draw request walks the Bresenham line from
// start to end, both ends included, and sets or clears each on-screen pixel; it is
// answered with a zero byte. A read request returns one store byte, or zero beyond the
// store. After reset the store is cleared one byte per cycle, and no request is taken
// until the clear is done. The line walker emits one pixel per cycle and the store does
// one read-modify-write per cycle on its single memory. One request is worked on at a
// time; a new one is taken while the previous response still waits at the output.
module bresenham_line_raster #(
    parameter int SCREEN_WIDTH  = blr_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = blr_pkg::DEF_SCREEN_HEIGHT
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_stall,
    input  wire                          kind,
    input  wire  [blr_pkg::X_W-1:0]      x_start,
    input  wire  [blr_pkg::Y_W-1:0]      y_start,
    input  wire  [blr_pkg::X_W-1:0]      x_end,
    input  wire  [blr_pkg::Y_W-1:0]      y_end,
    input  wire                          pixel_on,
    input  wire  [blr_pkg::IDX_W-1:0]    byte_index,
    output logic                         out_valid,
    input  wire                          out_stall,
    output logic [blr_pkg::DATA_W-1:0]   read_data
);

    localparam int PAGE_COUNT  = (SCREEN_HEIGHT + blr_pkg::PAGE_ROWS - 1) / blr_pkg::PAGE_ROWS;
    localparam int STORE_BYTES = PAGE_COUNT * SCREEN_WIDTH;
    localparam int ADDR_W      = $clog2(STORE_BYTES);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_DRAW  = 5'b00100,
        ST_READ  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t                     state_reg, state_next;
    logic                       out_valid_reg, out_valid_next;
    logic [blr_pkg::DATA_W-1:0] out_data_reg, out_data_next;
    logic                       res_read_reg, res_read_next;
    logic                       on_reg, on_next;
    logic [ADDR_W-1:0]          rd_addr_reg, rd_addr_next;

    logic                       clearing;
    logic                       accept;
    logic                       start_draw;
    logic                       index_in_store;
    logic                       load_out;
    blr_pkg::pixel_t            pixel;
    logic [blr_pkg::Y_W-1:0]    page;
    logic                       px_on_screen;
    logic                       px_valid;
    logic [ADDR_W-1:0]          px_addr;
    logic                       rd_valid;
    logic [blr_pkg::DATA_W-1:0] rd_data;

    assign accept         = in_valid && (state_reg == ST_IDLE);
    assign start_draw     = accept && (kind == blr_pkg::KIND_DRAW);
    assign index_in_store = (32'(byte_index) < 32'(STORE_BYTES));

    assign page         = pixel.y >> $clog2(blr_pkg::PAGE_ROWS);
    assign px_on_screen = (32'(pixel.x) < 32'(SCREEN_WIDTH)) &&
                          (32'(pixel.y) < 32'(SCREEN_HEIGHT));
    assign px_addr      = ADDR_W'(32'(page) * 32'(SCREEN_WIDTH) + 32'(pixel.x));
    assign px_valid     = (state_reg == ST_DRAW) && pixel.valid && px_on_screen;
    assign rd_valid     = (state_reg == ST_READ) && res_read_reg;

    blr_stepper u_stepper (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_draw),
        .x_start (x_start),
        .y_start (y_start),
        .x_end   (x_end),
        .y_end   (y_end),
        .pixel   (pixel)
    );

    blr_store #(
        .DEPTH  (STORE_BYTES),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .clearing (clearing),
        .px_valid (px_valid),
        .px_addr  (px_addr),
        .px_bit   (pixel.y[blr_pkg::BIT_W-1:0]),
        .px_on    (on_reg),
        .rd_valid (rd_valid),
        .rd_addr  (rd_addr_reg),
        .rd_data  (rd_data)
    );

    always_comb
    begin
        state_next    = state_reg;
        res_read_next = res_read_reg;
        on_next       = on_reg;
        rd_addr_next  = rd_addr_reg;
        load_out      = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                if (!clearing)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    on_next       = pixel_on;
                    rd_addr_next  = ADDR_W'(byte_index);
                    res_read_next = (kind == blr_pkg::KIND_READ) && index_in_store;
                    state_next    = (kind == blr_pkg::KIND_READ) ? ST_READ : ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                if (pixel.valid && pixel.last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res_read_reg ? rd_data : '0;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        res_read_reg <= res_read_next;
        on_reg       <= on_next;
        rd_addr_reg  <= rd_addr_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign read_data = out_data_reg;

endmodule

`default_nettype wire

### design/blr_stepper.sv
`default_nettype none

module blr_stepper (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      start,
    input  wire  [blr_pkg::X_W-1:0]  x_start,
    input  wire  [blr_pkg::Y_W-1:0]  y_start,
    input  wire  [blr_pkg::X_W-1:0]  x_end,
    input  wire  [blr_pkg::Y_W-1:0]  y_end,
    output blr_pkg::pixel_t          pixel
);

    localparam int EW = blr_pkg::ERR_W;

    logic                     busy_reg, busy_next;
    logic [blr_pkg::X_W-1:0]  x_reg, x_next;
    logic [blr_pkg::Y_W-1:0]  y_reg, y_next;
    logic [blr_pkg::X_W-1:0]  xe_reg, xe_next;
    logic [blr_pkg::Y_W-1:0]  ye_reg, ye_next;
    logic signed [EW-1:0]     dx_reg, dx_next;
    logic signed [EW-1:0]     dy_reg, dy_next;
    logic signed [EW-1:0]     err_reg, err_next;
    logic                     sx_neg_reg, sx_neg_next;
    logic                     sy_neg_reg, sy_neg_next;

    logic [blr_pkg::X_W-1:0]  dx_abs;
    logic [blr_pkg::Y_W-1:0]  dy_abs;
    logic signed [EW-1:0]     dx_start;
    logic signed [EW-1:0]     dy_start;
    logic signed [EW:0]       twice;
    logic signed [EW:0]       dx_wide;
    logic signed [EW:0]       dy_wide;
    logic                     step_x;
    logic                     step_y;
    logic                     at_end;

    assign dx_abs   = (x_end > x_start) ? (x_end - x_start) : (x_start - x_end);
    assign dy_abs   = (y_end > y_start) ? (y_end - y_start) : (y_start - y_end);
    assign dx_start = $signed(EW'(dx_abs));
    assign dy_start = -$signed(EW'(dy_abs));

    assign twice   = {err_reg, 1'b0};
    assign dx_wide = {dx_reg[EW-1], dx_reg};
    assign dy_wide = {dy_reg[EW-1], dy_reg};
    assign step_x  = (twice >= dy_wide);
    assign step_y  = (twice <= dx_wide);
    assign at_end  = (x_reg == xe_reg) && (y_reg == ye_reg);

    always_comb
    begin
        busy_next   = busy_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        xe_next     = xe_reg;
        ye_next     = ye_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        err_next    = err_reg;
        sx_neg_next = sx_neg_reg;
        sy_neg_next = sy_neg_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            x_next      = x_start;
            y_next      = y_start;
            xe_next     = x_end;
            ye_next     = y_end;
            dx_next     = dx_start;
            dy_next     = dy_start;
            err_next    = dx_start + dy_start;
            sx_neg_next = !(x_start < x_end);
            sy_neg_next = !(y_start < y_end);
        end
        else if (busy_reg)
        begin
            if (at_end)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                err_next = err_reg + (step_x ? dy_reg : '0) + (step_y ? dx_reg : '0);
                if (step_x)
                begin
                    x_next = sx_neg_reg ? (x_reg - 1'b1) : (x_reg + 1'b1);
                end
                if (step_y)
                begin
                    y_next = sy_neg_reg ? (y_reg - 1'b1) : (y_reg + 1'b1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        xe_reg     <= xe_next;
        ye_reg     <= ye_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        err_reg    <= err_next;
        sx_neg_reg <= sx_neg_next;
        sy_neg_reg <= sy_neg_next;
    end

    assign pixel.valid = busy_reg;
    assign pixel.last  = at_end;
    assign pixel.x     = x_reg;
    assign pixel.y     = y_reg;

endmodule

`default_nettype wire

### design/blr_store.sv
`default_nettype none

module blr_store #(
    parameter int DEPTH  = blr_pkg::DEF_STORE_BYTES,
    parameter int ADDR_W = blr_pkg::DEF_ADDR_W
) (
    input  wire                          clk,
    input  wire                          rst_n,
    output logic                         clearing,
    input  wire                          px_valid,
    input  wire  [ADDR_W-1:0]            px_addr,
    input  wire  [blr_pkg::BIT_W-1:0]    px_bit,
    input  wire                          px_on,
    input  wire                          rd_valid,
    input  wire  [ADDR_W-1:0]            rd_addr,
    output logic [blr_pkg::DATA_W-1:0]   rd_data
);

    localparam int DW = blr_pkg::DATA_W;

    logic [DW-1:0]     mem [DEPTH];
    logic [DW-1:0]     rdata_reg;

    logic              clear_reg, clear_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;

    logic                      wr_valid_reg;
    logic [ADDR_W-1:0]         wr_addr_reg;
    logic [blr_pkg::BIT_W-1:0] wr_bit_reg;
    logic                      wr_on_reg;

    logic              fwd_valid_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic [DW-1:0]     fwd_data_reg;

    logic              mem_ren;
    logic [ADDR_W-1:0] mem_raddr;
    logic              mem_wen;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DW-1:0]     mem_wdata;
    logic [DW-1:0]     base_byte;
    logic [DW-1:0]     bit_mask;
    logic [DW-1:0]     new_byte;

    assign mem_ren   = px_valid || rd_valid;
    assign mem_raddr = px_valid ? px_addr : rd_addr;

    // The byte written in the previous cycle is not yet visible on the read port.
    assign base_byte = (fwd_valid_reg && (fwd_addr_reg == wr_addr_reg)) ? fwd_data_reg
                                                                        : rdata_reg;
    assign bit_mask  = DW'(1) << wr_bit_reg;
    assign new_byte  = wr_on_reg ? (base_byte | bit_mask) : (base_byte & ~bit_mask);

    assign mem_wen   = clear_reg || wr_valid_reg;
    assign mem_waddr = clear_reg ? clr_addr_reg : wr_addr_reg;
    assign mem_wdata = clear_reg ? '0 : new_byte;

    always_comb
    begin
        clear_next    = clear_reg;
        clr_addr_next = clr_addr_reg;
        if (clear_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clear_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_wen)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_ren)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg     <= 1'b1;
            clr_addr_reg  <= '0;
            wr_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            clear_reg    <= clear_next;
            clr_addr_reg <= clr_addr_next;
            wr_valid_reg <= px_valid;
            if (wr_valid_reg)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg <= px_addr;
        wr_bit_reg  <= px_bit;
        wr_on_reg   <= px_on;
        if (wr_valid_reg)
        begin
            fwd_addr_reg <= wr_addr_reg;
            fwd_data_reg <= new_byte;
        end
    end

    assign clearing = clear_reg;
    assign rd_data  = rdata_reg;

endmodule

`default_nettype wire

### design/blr_props.sv
`default_nettype none

`include "bresenham_line_raster_macros.svh"

module blr_props (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          in_valid,
    input wire                          in_stall,
    input wire                          out_valid,
    input wire                          out_stall,
    input wire [blr_pkg::DATA_W-1:0]    read_data
);

    // Every request keeps the block busy after acceptance, through its work state and the done state.
    `BLR_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall ##1 in_stall, "request taken while the previous one was still in work")

    // When a new response appears, the block is free for the next request in the same cycle.
    `BLR_ASSERT_SAME(a_free_on_response, $rose(out_valid), !in_stall, "response shown while the block stays busy")

    `BLR_ASSERT_NEXT(a_response_held, out_valid && out_stall, out_valid && $stable(read_data), "stalled response changed or dropped")

endmodule

bind bresenham_line_raster blr_props u_blr_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .read_data (read_data)
);

`default_nettype wire

### test/bresenham_line_raster_tb.sv
`default_nettype none

module bresenham_line_raster_tb;

    localparam int X_W         = blr_pkg::X_W;
    localparam int Y_W         = blr_pkg::Y_W;
    localparam int IDX_W       = blr_pkg::IDX_W;
    localparam int DATA_W      = blr_pkg::DATA_W;
    localparam int X_MAX       = (1 << X_W) - 1;
    localparam int Y_MAX       = (1 << Y_W) - 1;
    localparam int IDX_MAX     = (1 << IDX_W) - 1;
    localparam int STUCK_LIMIT = 4000;
    localparam int RANDOM_REQS = 550;

    typedef struct {
        logic              kind;
        logic [X_W-1:0]    xs;
        logic [Y_W-1:0]    ys;
        logic [X_W-1:0]    xe;
        logic [Y_W-1:0]    ye;
        logic              on;
        logic [IDX_W-1:0]  idx;
    } raster_req_t;

    class raster_scoreboard;
        logic [DATA_W-1:0] frame_bytes [blr_pkg::DEF_STORE_BYTES];
        logic [DATA_W-1:0] expected_bytes [$];
        int draws_set;
        int draws_cleared;
        int reads;
        int lit_reads;
        int checked;

        function new();
            foreach (frame_bytes[i])
                frame_bytes[i] = '0;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void plot_pixel(int x, int y, bit on);
            int idx;
            logic [DATA_W-1:0] mask;
            if (x < 0 || y < 0 || x >= blr_pkg::DEF_SCREEN_WIDTH ||
                y >= blr_pkg::DEF_SCREEN_HEIGHT)
                return;
            idx = (y / blr_pkg::PAGE_ROWS) * blr_pkg::DEF_SCREEN_WIDTH + x;
            if (idx >= blr_pkg::DEF_STORE_BYTES)
                return;
            mask = DATA_W'(1) << (y % blr_pkg::PAGE_ROWS);
            if (on)
                frame_bytes[idx] = frame_bytes[idx] | mask;
            else
                frame_bytes[idx] = frame_bytes[idx] & ~mask;
        endfunction

        function void trace_line(int xa, int ya, int xb, int yb, bit on);
            int dx;
            int dy;
            int sx;
            int sy;
            int err;
            int twice;
            dx  = (xb > xa) ? xb - xa : xa - xb;
            dy  = -((yb > ya) ? yb - ya : ya - yb);
            sx  = (xa < xb) ? 1 : -1;
            sy  = (ya < yb) ? 1 : -1;
            err = dx + dy;
            while (1'b1)
            begin
                plot_pixel(xa, ya, on);
                if (xa == xb && ya == yb)
                    break;
                twice = 2 * err;
                if (twice >= dy)
                begin
                    err += dy;
                    xa  += sx;
                end
                if (twice <= dx)
                begin
                    err += dx;
                    ya  += sy;
                end
            end
        endfunction

        function void note_request(raster_req_t r);
            if (r.kind == blr_pkg::KIND_DRAW)
            begin
                trace_line(int'(r.xs), int'(r.ys), int'(r.xe), int'(r.ye), r.on);
                expected_bytes.push_back('0);
                if (r.on)
                    draws_set++;
                else
                    draws_cleared++;
            end
            else
            begin
                reads++;
                if (r.idx < blr_pkg::DEF_STORE_BYTES)
                    expected_bytes.push_back(frame_bytes[r.idx]);
                else
                    expected_bytes.push_back('0);
                if (expected_bytes[$] != 0)
                    lit_reads++;
            end
        endfunction

        function bit check_result(input logic [DATA_W-1:0] got,
                                  output logic [DATA_W-1:0] want, output bit orphan);
            orphan = (expected_bytes.size() == 0);
            want   = '0;
            if (orphan)
                return 1'b0;
            want = expected_bytes.pop_front();
            checked++;
            return (got === want);
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                kind;
    logic [X_W-1:0]      x_start;
    logic [Y_W-1:0]      y_start;
    logic [X_W-1:0]      x_end;
    logic [Y_W-1:0]      y_end;
    logic                pixel_on;
    logic [IDX_W-1:0]    byte_index;
    logic                out_valid;
    logic                out_stall;
    logic [DATA_W-1:0]   read_data;

    raster_scoreboard    raster_sb = new();
    int                  mismatch_count;
    int                  stuck_cycles;
    int                  rx_hold_cycles;
    bit                  rx_idle_en;
    bit                  tx_idle_en;
    int                  recent_bytes [2];

    bresenham_line_raster dut (.*);

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function automatic raster_req_t draw_req(int xs, int ys, int xe, int ye, bit on);
        raster_req_t r;
        r.kind = blr_pkg::KIND_DRAW;
        r.xs   = X_W'(xs);
        r.ys   = Y_W'(ys);
        r.xe   = X_W'(xe);
        r.ye   = Y_W'(ye);
        r.on   = on;
        r.idx  = IDX_W'($urandom_range(0, IDX_MAX));
        recent_bytes[0] = (ys / blr_pkg::PAGE_ROWS) * blr_pkg::DEF_SCREEN_WIDTH + xs;
        recent_bytes[1] = (ye / blr_pkg::PAGE_ROWS) * blr_pkg::DEF_SCREEN_WIDTH + xe;
        return r;
    endfunction

    function automatic raster_req_t read_req(int idx);
        raster_req_t r;
        r.kind = blr_pkg::KIND_READ;
        r.xs   = X_W'($urandom_range(0, X_MAX));
        r.ys   = Y_W'($urandom_range(0, Y_MAX));
        r.xe   = X_W'($urandom_range(0, X_MAX));
        r.ye   = Y_W'($urandom_range(0, Y_MAX));
        r.on   = 1'($urandom_range(0, 1));
        r.idx  = IDX_W'(idx);
        return r;
    endfunction

    function automatic raster_req_t random_req();
        int xs;
        int ys;
        int xe;
        int ye;
        xs = $urandom_range(0, X_MAX);
        ys = $urandom_range(0, Y_MAX);
        if ($urandom_range(0, 1))
        begin
            if ($urandom_range(0, 1))
                return read_req(recent_bytes[$urandom_range(0, 1)]);
            return read_req($urandom_range(0, IDX_MAX));
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                xe = xs + int'($urandom_range(0, 16)) - 8;
                ye = ys + int'($urandom_range(0, 8)) - 4;
            end
            4:
            begin
                xe = $urandom_range(0, X_MAX);
                ye = ys;
            end
            5:
            begin
                xe = xs;
                ye = $urandom_range(0, Y_MAX);
            end
            6:
            begin
                xe = xs;
                ye = ys;
            end
            default:
            begin
                xe = $urandom_range(0, X_MAX);
                ye = $urandom_range(0, Y_MAX);
            end
        endcase
        xe = (xe < 0) ? 0 : (xe > X_MAX) ? X_MAX : xe;
        ye = (ye < 0) ? 0 : (ye > Y_MAX) ? Y_MAX : ye;
        return draw_req(xs, ys, xe, ye, $urandom_range(0, 3) != 0);
    endfunction

    task automatic send_request(input raster_req_t r);
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= r.kind;
        x_start    <= r.xs;
        y_start    <= r.ys;
        x_end      <= r.xe;
        y_end      <= r.ye;
        pixel_on   <= r.on;
        byte_index <= r.idx;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
    endtask

    always @(posedge clk)
    begin : monitor
        bit                 in_taken;
        bit                 out_taken;
        bit                 orphan;
        logic [DATA_W-1:0]  want;
        raster_req_t        r;
        if (rst_n === 1'b1)
        begin
            in_taken  = (in_valid === 1'b1 && in_stall === 1'b0);
            out_taken = (out_valid === 1'b1 && out_stall === 1'b0);
            if (out_taken && !raster_sb.check_result(read_data, want, orphan))
            begin
                if (orphan)
                    report_mismatch($sformatf("response %h with no request outstanding",
                                              read_data));
                else
                    report_mismatch($sformatf("response %0d: read_data %h, expected %h",
                                              raster_sb.checked, read_data, want));
            end
            if (in_taken)
            begin
                r.kind = kind;
                r.xs   = x_start;
                r.ys   = y_start;
                r.xe   = x_end;
                r.ye   = y_end;
                r.on   = pixel_on;
                r.idx  = byte_index;
                raster_sb.note_request(r);
            end
            stuck_cycles = (in_taken || out_taken) ? 0 : stuck_cycles + 1;
        end
    end

    initial
    begin : receiver
        int n;
        @(posedge clk);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                out_stall      <= 1'b1;
                n              = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            else if (rx_idle_en && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                n         = $urandom_range(1, 9);
            end
            else
            begin
                out_stall <= 1'b0;
                n         = $urandom_range(1, 16);
            end
            repeat (n) @(posedge clk);
        end
    end

    initial
    begin : watchdog
        wait (rst_n === 1'b1);
        while (stuck_cycles < STUCK_LIMIT)
            @(posedge clk);
        $display("timeout after %0d cycles without a handshake", STUCK_LIMIT);
        $display("FAIL bresenham_line_raster");
        $finish;
    end

    initial
    begin : stimulus
        bit tx_mode;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        kind           = blr_pkg::KIND_DRAW;
        x_start        = '0;
        y_start        = '0;
        x_end          = '0;
        y_end          = '0;
        pixel_on       = 1'b0;
        byte_index     = '0;
        out_stall      = 1'b0;
        rx_idle_en     = 1'b1;
        tx_idle_en     = 1'b1;
        rx_hold_cycles = 0;
        tx_mode        = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // The store must read back as cleared, then single pixels, edges, one diagonal and two
        // slanted lines are drawn, partly erased, also along the other diagonal, and read back.
        send_request(read_req(0));
        send_request(read_req(IDX_MAX));
        send_request(draw_req(0, 0, 0, 0, 1'b1));
        send_request(read_req(0));
        send_request(draw_req(X_MAX, Y_MAX, X_MAX, Y_MAX, 1'b1));
        send_request(read_req(IDX_MAX));
        send_request(draw_req(0, 0, X_MAX, 0, 1'b1));
        send_request(read_req(64));
        send_request(draw_req(0, Y_MAX, 0, 0, 1'b1));
        send_request(read_req(384));
        send_request(draw_req(X_MAX, 0, 0, Y_MAX, 1'b1));
        send_request(read_req(blr_pkg::DEF_SCREEN_WIDTH + 95));
        send_request(draw_req(5, 3, 60, 29, 1'b1));
        send_request(draw_req(100, 30, 90, 2, 1'b1));
        send_request(read_req(2 * blr_pkg::DEF_SCREEN_WIDTH + 94));
        send_request(draw_req(X_MAX, 0, 0, 0, 1'b0));
        send_request(read_req(0));
        send_request(read_req(X_MAX));
        send_request(draw_req(10, 10, 10, 10, 1'b1));
        send_request(read_req(blr_pkg::DEF_SCREEN_WIDTH + 10));
        send_request(draw_req(10, 10, 10, 10, 1'b0));
        send_request(read_req(blr_pkg::DEF_SCREEN_WIDTH + 10));
        send_request(draw_req(X_MAX, Y_MAX, 0, 0, 1'b0));
        send_request(read_req(IDX_MAX));
        send_request(read_req(256));

        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            if (i % 50 == 0)
            begin
                tx_mode    = $urandom_range(0, 3) != 0;
                rx_idle_en = $urandom_range(0, 3) != 0;
            end
            // The receiver holds off while requests keep coming, so the block backs up.
            if (i == 150)
                rx_hold_cycles = 400;
            // Here the sender drains the block completely before going on.
            if (i == 300)
            begin
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (raster_sb.pending() != 0);
            end
            if (i >= 450)
                rx_idle_en = 1'b0;
            tx_idle_en = tx_mode && !(i >= 150 && i < 165) && i < 450;
            send_request(random_req());
        end

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (raster_sb.pending() != 0);
        repeat (140) @(posedge clk);

        $display("Drew %0d setting and %0d clearing lines, read %0d store bytes (%0d nonzero).",
                 raster_sb.draws_set, raster_sb.draws_cleared, raster_sb.reads,
                 raster_sb.lit_reads);
        $display("Checked %0d responses, %0d mismatches.", raster_sb.checked, mismatch_count);
        if (mismatch_count == 0 && raster_sb.pending() == 0)
            $display("PASS bresenham_line_raster");
        else
            $display("FAIL bresenham_line_raster");
        $finish;
    end

endmodule

`default_nettype wire
